>>> src/mstq_pkg.sv
// ----------------------------------------------------------------------------
// mstq_pkg
// Shared types and constants for the Morse symbol timing queue.
// ----------------------------------------------------------------------------
package mstq_pkg;

	localparam int SLOTS           = 8;
	localparam int SLOT_W          = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int DAH_UNITS       = 3;
	localparam int DIT_UNITS       = 1;
	localparam int INNER_GAP_UNITS = 1;

	localparam int CFG_W     = 10;
	localparam int CFG_IDX_W = 1;
	localparam int TICK_W    = 16;

	localparam logic [CFG_W-1:0] UNIT_TICKS_RESET = CFG_W'(29);

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_UNIT_TICKS        = 1'b0,
		CFG_SPACED_UNIT_TICKS = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		FUNC_ENQUEUE = 1'b0,
		FUNC_NEXT    = 1'b1
	} func_t;

	typedef struct packed {
		logic       func;
		logic [3:0] element_count;
		logic [7:0] element_bits;
		logic [3:0] closing_gap;
	} in_t;

	typedef struct packed {
		logic              accepted;
		logic              finished;
		logic              tone_on;
		logic [TICK_W-1:0] tone_ticks;
		logic [TICK_W-1:0] period_ticks;
	} out_t;

endpackage

>>> src/morse_symbol_timing_queue.sv
// ----------------------------------------------------------------------------
// morse_symbol_timing_queue
// Ring of queued Morse characters; pops one element per timer event and
// returns its tone length and tone-plus-gap period, with Farnsworth stretch.
// ----------------------------------------------------------------------------
//  channel  direction  handshake              payload
//  in       input      in_valid / in_stall    in_data   (mstq_pkg::in_t)
//  out      output     out_valid / out_stall  out_data  (mstq_pkg::out_t)
//  cfg      input      cfg_wr_en              cfg_index, cfg_wdata
//
//  enqueue and empty-ring events: result goes from res_q through S_OUT into out_data
//  element pop: steps S_ELEM, S_MUL2, then S_MUL3 when the gap is stretched, then S_OUT,
//  built on the registered slot memory read and the single shared 16x10 multiplier
//  one item in flight; in_stall is high until its result is in out_data
//  a held result does not block the next input transfer, only the next result
//  arst_n clears pointers, flags and registers; slot entries are written before read
// ----------------------------------------------------------------------------
module morse_symbol_timing_queue (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  mstq_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_stall,
	output mstq_pkg::out_t                      out_data,
	input  logic                                cfg_wr_en,
	input  logic [mstq_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mstq_pkg::CFG_W-1:0]          cfg_wdata
);
	import mstq_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ELEM,
		S_MUL2,
		S_MUL3,
		S_OUT
	} state_t;

	state_t              state_q;
	logic [CFG_W-1:0]    unit_q;
	logic [CFG_W-1:0]    spaced_q;
	logic [SLOT_W-1:0]   rd_q;
	logic [SLOT_W-1:0]   wr_q;
	logic                last_was_read_q;
	logic [7:0]          char_units_q;

	logic [15:0]         slot_mem [SLOTS];
	logic [15:0]         rd_data_q;

	logic [7:0]          cu_work_q;
	logic [2:0]          sym_q;
	logic [3:0]          space_q;
	logic                stretch_q;
	logic [TICK_W-1:0]   tone_q;
	logic [TICK_W-1:0]   acc_q;
	out_t                res_q;
	out_t                out_q;
	logic                out_valid_q;

	logic                in_fire;
	logic                out_load;
	logic                ring_eq;
	logic                ring_full;
	logic                ring_empty;
	logic                mem_we;
	logic [SLOT_W-1:0]   mem_waddr;
	logic [15:0]         mem_wdata;

	logic [7:0]          el_low;
	logic [7:0]          el_mask;
	logic [2:0]          el_sym;
	logic                el_last;
	logic [3:0]          el_space;
	logic [7:0]          el_cu;
	logic                el_stretch;

	logic [15:0]         mul_a;
	logic [CFG_W-1:0]    mul_b;
	logic [15+CFG_W:0]   mul_full;
	logic [TICK_W-1:0]   mul_p;

	function automatic logic [SLOT_W-1:0] slot_next(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		if (s == SLOT_W'(SLOTS - 1)) begin
			r = '0;
		end else begin
			r = s + SLOT_W'(1);
		end
		return r;
	endfunction

	assign in_stall   = (state_q != S_IDLE);
	assign in_fire    = in_valid && !in_stall;
	assign out_load   = (state_q == S_OUT) && (!out_valid_q || !out_stall);
	assign ring_eq    = (rd_q == wr_q);
	assign ring_full  = !last_was_read_q && ring_eq;
	assign ring_empty = last_was_read_q && ring_eq;
	assign out_valid  = out_valid_q;
	assign out_data   = out_q;

	// element decode from the slot read at accept time
	assign el_low     = rd_data_q[7:0] - 8'd1;
	assign el_mask    = rd_data_q[15:8];
	assign el_sym     = el_mask[0] ? 3'(DAH_UNITS) : 3'(DIT_UNITS);
	assign el_last    = (el_low[3:0] == 4'd0);
	assign el_space   = el_last ? el_low[7:4] : 4'(INNER_GAP_UNITS);
	assign el_cu      = char_units_q + 8'(el_space) + 8'(el_sym);
	assign el_stretch = el_last && (spaced_q != unit_q);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wr_q;
		mem_wdata = {in_data.element_bits, in_data.closing_gap, in_data.element_count};
		if (state_q == S_ELEM) begin
			mem_we    = 1'b1;
			mem_waddr = rd_q;
			mem_wdata = el_last ? 16'd0 : {1'b0, el_mask[7:1], el_low};
		end else if (in_fire && in_data.func == FUNC_ENQUEUE && !ring_full) begin
			mem_we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= slot_mem[rd_q];
	end

	// one shared multiplier, operands picked by step
	always_comb begin
		mul_a = '0;
		mul_b = unit_q;
		unique case (state_q)
			S_ELEM: mul_a = 16'(el_sym);
			S_MUL2: begin
				if (stretch_q) begin
					mul_a = {8'd0, cu_work_q};
					mul_b = spaced_q;
				end else begin
					mul_a = 16'(sym_q) + 16'(space_q);
				end
			end
			S_MUL3: mul_a = {8'd0, cu_work_q} - {12'd0, space_q};
			default: mul_a = '0;
		endcase
	end

	assign mul_full = mul_a * mul_b;
	assign mul_p    = mul_full[TICK_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_q   <= UNIT_TICKS_RESET;
			spaced_q <= UNIT_TICKS_RESET;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_UNIT_TICKS:        unit_q   <= cfg_wdata;
				CFG_SPACED_UNIT_TICKS: spaced_q <= cfg_wdata;
				default:               unit_q   <= unit_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			rd_q            <= '0;
			wr_q            <= '0;
			last_was_read_q <= 1'b1;
			char_units_q    <= '0;
			cu_work_q       <= '0;
			sym_q           <= '0;
			space_q         <= '0;
			stretch_q       <= 1'b0;
			tone_q          <= '0;
			acc_q           <= '0;
			res_q           <= '0;
			out_q           <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						res_q.accepted     <= (in_data.func == FUNC_ENQUEUE) && !ring_full;
						res_q.finished     <= (in_data.func == FUNC_NEXT) && ring_empty;
						res_q.tone_on      <= 1'b0;
						res_q.tone_ticks   <= '0;
						res_q.period_ticks <= '0;
						if (in_data.func == FUNC_ENQUEUE) begin
							state_q <= S_OUT;
							if (!ring_full) begin
								wr_q            <= slot_next(wr_q);
								last_was_read_q <= 1'b0;
							end
						end else if (ring_empty) begin
							state_q <= S_OUT;
						end else begin
							state_q <= S_ELEM;
						end
					end
				end
				S_ELEM: begin
					tone_q    <= mul_p;
					sym_q     <= el_sym;
					space_q   <= el_space;
					cu_work_q <= el_cu;
					stretch_q <= el_stretch;
					char_units_q <= el_stretch ? 8'd0 : el_cu;
					if (el_last) begin
						rd_q            <= slot_next(rd_q);
						last_was_read_q <= 1'b1;
					end
					state_q <= S_MUL2;
				end
				S_MUL2: begin
					res_q.accepted   <= 1'b0;
					res_q.finished   <= 1'b0;
					res_q.tone_on    <= 1'b1;
					res_q.tone_ticks <= tone_q;
					if (stretch_q) begin
						acc_q   <= tone_q + mul_p;
						state_q <= S_MUL3;
					end else begin
						res_q.period_ticks <= mul_p;
						state_q            <= S_OUT;
					end
				end
				S_MUL3: begin
					// effective length minus what the character already used
					res_q.period_ticks <= acc_q - mul_p;
					state_q            <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_result_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> $onehot0({out_q.accepted, out_q.finished, out_q.tone_on}))
		else $error("result carries more than one kind flag");

	a_pop_reads_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_data.func == FUNC_NEXT && !ring_empty) |=> state_q == S_ELEM)
		else $error("pop on a filled ring did not start an element");

	a_full_keeps_ring: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && in_data.func == FUNC_ENQUEUE && ring_full) |=> $stable(wr_q))
		else $error("refused enqueue moved the write slot");

	a_stretch_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ELEM && el_stretch) |=> char_units_q == 8'd0)
		else $error("stretched character did not clear its unit count");

	a_slot_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(rd_q) < SLOTS) && (int'(wr_q) < SLOTS))
		else $error("slot pointer out of range");
`endif

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives enqueue and next-symbol transfers into the Morse symbol timing queue
// under random idling, a long output hold-off and changing unit lengths, and
// checks every result against a local model of the ring and its timing.
// ----------------------------------------------------------------------------
module testbench;
	import mstq_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 8;

	logic             clk;
	logic             arst_n;
	logic             in_valid;
	logic             in_stall;
	in_t              in_data;
	logic             out_valid;
	logic             out_stall;
	out_t             out_data;
	logic             cfg_wr_en;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;

	morse_symbol_timing_queue i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// local copy of the ring and timing state
	logic [15:0]       slot_mem [SLOTS];
	logic [SLOT_W-1:0] rd_ptr = '0;
	logic [SLOT_W-1:0] wr_ptr = '0;
	bit                ring_drained = 1'b1;
	logic [7:0]        char_units = '0;
	logic [CFG_W-1:0]  unit_len = UNIT_TICKS_RESET;
	logic [CFG_W-1:0]  spaced_len = UNIT_TICKS_RESET;

	out_t timing_q [$];

	bit tx_quiet = 1'b0;
	bit rx_quiet = 1'b0;
	int rx_hold_len = 0;
	int idle_cycles = 0;

	int mismatches = 0;
	int n_sent = 0;
	int n_checked = 0;
	int n_stored = 0;
	int n_refused = 0;
	int n_finished = 0;
	int n_tones = 0;
	int n_stretched = 0;
	int n_settings = 0;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic out_t predict_timing(in_t item);
		out_t        r;
		logic [7:0]  low;
		logic [7:0]  pattern;
		int unsigned sym;
		int unsigned space;
		int unsigned u;
		int unsigned cu;
		bit          last;
		logic [15:0] eff;
		logic [15:0] sent;
		r = '0;
		if (item.func == FUNC_ENQUEUE) begin
			if (!ring_drained && wr_ptr == rd_ptr) begin
				n_refused++;
				return r;
			end
			slot_mem[wr_ptr] = {item.element_bits, item.closing_gap, item.element_count};
			wr_ptr = wr_ptr + 1'b1;
			ring_drained = 1'b0;
			n_stored++;
			r.accepted = 1'b1;
			return r;
		end
		if (ring_drained && wr_ptr == rd_ptr) begin
			n_finished++;
			r.finished = 1'b1;
			return r;
		end
		// gap and count are decremented as one byte, so a zero count borrows
		low = slot_mem[rd_ptr][7:0] - 8'd1;
		pattern = slot_mem[rd_ptr][15:8];
		sym = pattern[0] ? DAH_UNITS : DIT_UNITS;
		last = (low[3:0] == 4'd0);
		if (last) begin
			space = 32'(low[7:4]);
			slot_mem[rd_ptr] = '0;
			rd_ptr = rd_ptr + 1'b1;
			ring_drained = 1'b1;
		end else begin
			space = INNER_GAP_UNITS;
			slot_mem[rd_ptr] = {pattern >> 1, low};
		end
		u = 32'(unit_len);
		r.tone_on = 1'b1;
		r.tone_ticks = 16'(sym * u);
		char_units = 8'(char_units + space + sym);
		if (last && spaced_len != unit_len) begin
			// stretch the closing gap so the character spans char_units spaced dits
			cu = 32'(char_units);
			eff = 16'(cu * spaced_len);
			sent = 16'((cu - space) * u);
			r.period_ticks = r.tone_ticks + eff - sent;
			char_units = '0;
			n_stretched++;
		end else begin
			r.period_ticks = 16'((sym + space) * u);
		end
		n_tones++;
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin : check_results
		out_t want;
		if (arst_n && out_valid && !out_stall) begin
			n_checked++;
			if (timing_q.size() == 0) begin
				$error("result transfer with nothing pending: %p", out_data);
				mismatches++;
			end else begin
				want = timing_q.pop_front();
				check_field("accepted", want.accepted, out_data.accepted);
				check_field("finished", want.finished, out_data.finished);
				check_field("tone_on", want.tone_on, out_data.tone_on);
				check_field("tone_ticks", want.tone_ticks, out_data.tone_ticks);
				check_field("period_ticks", want.period_ticks, out_data.period_ticks);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
			idle_cycles <= 0;
		end else if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
			$display("** morse_symbol_timing_queue: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// receiver: random stalls, quiet stretches, and counted hold-offs
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold_len > 0) begin
				out_stall <= 1'b1;
				rx_hold_len--;
			end else if (rx_quiet) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < 27);
			end
		end
	end

	// the first negedge after a transfer must either offer a new item or drop valid
	task automatic send_item(in_t item);
		@(negedge clk);
		while (!tx_quiet && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		timing_q.push_back(predict_timing(item));
		n_sent++;
	endtask

	task automatic wait_drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (timing_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_W-1:0] value);
		wait_drain();
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		if (idx == CFG_UNIT_TICKS) unit_len = value;
		else spaced_len = value;
	endtask

	task automatic set_lengths(logic [CFG_W-1:0] unit, logic [CFG_W-1:0] spaced);
		write_reg(CFG_UNIT_TICKS, unit);
		write_reg(CFG_SPACED_UNIT_TICKS, spaced);
		n_settings++;
	endtask

	function automatic in_t make_char(logic [3:0] count, logic [7:0] bits, logic [3:0] gap);
		in_t item;
		item.func = FUNC_ENQUEUE;
		item.element_count = count;
		item.element_bits = bits;
		item.closing_gap = gap;
		return item;
	endfunction

	function automatic in_t rand_item(int unsigned enq_pct);
		in_t         item;
		int unsigned pick;
		item.func = ($urandom_range(99) < enq_pct) ? FUNC_ENQUEUE : FUNC_NEXT;
		pick = $urandom_range(99);
		// short characters mostly, so closing gaps come often
		if (pick < 70) item.element_count = 4'($urandom_range(4, 1));
		else if (pick < 80) item.element_count = 4'd0;
		else if (pick < 90) item.element_count = 4'd15;
		else item.element_count = 4'($urandom_range(14, 5));
		item.element_bits = 8'($urandom_range(255));
		item.closing_gap = 4'($urandom_range(15));
		return item;
	endfunction

	task automatic test_full_ring();
		in_t nxt;
		nxt = rand_item(0);
		set_lengths(UNIT_TICKS_RESET, UNIT_TICKS_RESET);
		send_item(nxt);
		for (int i = 0; i < SLOTS; i++) begin
			send_item(make_char(4'd1, (i % 2) ? 8'hff : 8'h00, (i % 2) ? 4'd15 : 4'd0));
		end
		// one more than the ring holds is refused
		send_item(make_char(4'd1, 8'h01, 4'd3));
		for (int i = 0; i <= SLOTS; i++) send_item(nxt);
	endtask

	task automatic test_farnsworth();
		logic [CFG_W-1:0] units [4] = '{10'd1, 10'd586, 10'd0, 10'd1023};
		logic [CFG_W-1:0] spaced [4] = '{10'd586, 10'd1, 10'd1023, 10'd0};
		for (int i = 0; i < 4; i++) begin
			set_lengths(units[i], spaced[i]);
			send_item(make_char(4'd1, 8'(i), 4'd7));
			send_item(rand_item(0));
		end
	endtask

	task automatic test_zero_count();
		set_lengths(10'd29, 10'd58);
		// count borrows from the gap and wraps to sixteen elements
		send_item(make_char(4'd0, 8'hA5, 4'd3));
		send_item(rand_item(0));
		send_item(rand_item(0));
	endtask

	task automatic test_backpressure();
		set_lengths(CFG_W'($urandom_range(586, 1)), CFG_W'($urandom_range(586, 1)));
		rx_hold_len = 100;
		tx_quiet = 1'b1;
		for (int i = 0; i < 24; i++) send_item(rand_item(50));
		tx_quiet = 1'b0;
		wait_drain();
		for (int i = 0; i < 24; i++) send_item(rand_item(50));
	endtask

	task automatic test_random();
		int unsigned enq_pct;
		for (int phase = 0; phase < 10; phase++) begin
			case ($urandom_range(5))
				0: set_lengths(unit_len, unit_len);
				1: set_lengths(10'd1, 10'd586);
				2: set_lengths(10'd586, 10'd1);
				3: set_lengths(CFG_W'($urandom_range(1023)), CFG_W'($urandom_range(1023)));
				default: set_lengths(CFG_W'($urandom_range(586, 1)),
					CFG_W'($urandom_range(586, 1)));
			endcase
			enq_pct = 30 + 20 * $urandom_range(2);
			tx_quiet = (phase == 4);
			rx_quiet = (phase == 4);
			for (int i = 0; i < 78; i++) send_item(rand_item(enq_pct));
		end
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	initial begin
		foreach (slot_mem[i]) slot_mem[i] = '0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_wr_en = 1'b0;
		cfg_index = CFG_UNIT_TICKS;
		cfg_wdata = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_full_ring();
		test_farnsworth();
		test_zero_count();
		test_backpressure();
		test_random();
		wait_drain();

		$display("%0d transfers in, %0d results checked, %0d unit-length settings",
			n_sent, n_checked, n_settings);
		$display("stored %0d, refused %0d, empty-ring %0d, tones %0d (%0d stretched gaps)",
			n_stored, n_refused, n_finished, n_tones, n_stretched);
		if (mismatches == 0) begin
			$display("** morse_symbol_timing_queue: PASSED **");
		end else begin
			$display("** morse_symbol_timing_queue: FAILED **");
		end
		$finish;
	end

endmodule

>>> morse_symbol_timing_queue.f
src/mstq_pkg.sv
src/morse_symbol_timing_queue.sv
verif/testbench.sv
